@@ src/pbrd_pkg.sv @@
// shared types and constants for the pulse beat rate detector
package pbrd_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AVG_PERIOD  = 3'd0,
    REG_WAVE_LOW    = 3'd1,
    REG_WAVE_HIGH   = 3'd2,
    REG_PERIOD_LOW  = 3'd3,
    REG_PERIOD_HIGH = 3'd4,
    REG_RATE_LOW    = 3'd5,
    REG_RATE_HIGH   = 3'd6,
    REG_STABILITY   = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_NO_BEAT     = 3'd0,
    ST_LEVEL_OUT   = 3'd1,
    ST_PERIOD_OUT  = 3'd2,
    ST_RATE_OUT    = 3'd3,
    ST_UNSTABLE    = 3'd4,
    ST_VALID       = 3'd5
  } beat_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MEAN,
    BK_SMOOTH,
    BK_RATE,
    BK_CLASS,
    BK_OUT
  } back_state_t;

  localparam logic [33:0] RATE_NUM   = 34'd6000000;
  localparam logic [15:0] RATE_SAT   = 16'hFFFF;
  localparam logic [15:0] RATE_RESET = 16'd600;
  localparam logic [7:0]  RISE_LIMIT = 8'd4;
  localparam logic [16:0] WAVE_RESET = 17'd65536;

  // divider width: mean numerator needs up to 40 bits at the widest count,
  // the rate numerator up to 36
  localparam int unsigned DIV_W = 40;

  typedef struct packed {
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

endpackage

@@ src/pbrd_divider.sv @@
// shared restoring divider, one quotient bit per cycle
module pbrd_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  pbrd_pkg::div_req_t          req,
  output logic                        done,
  output logic [pbrd_pkg::DIV_W-1:0]  quot
);
  localparam int unsigned W  = pbrd_pkg::DIV_W;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r;
  logic [W:0]    trial;

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, q_r[W-1]};
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = req.num;
      den_nxt  = req.den;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = W'(trial - {1'b0, den_r});
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      // quotient is complete the cycle after the last iteration
      done_r <= busy_r && (cnt_r == CW'(1)) && !start;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

@@ src/pbrd_front.sv @@
// front end: window accumulation and close detection
module pbrd_front #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [11:0]             sample,
  input  logic [31:0]             now_ms,
  input  logic [15:0]             avg_period,
  output logic                    win_close,
  output logic [12+COUNT_WIDTH-1:0] win_sum,
  output logic [COUNT_WIDTH-1:0]  win_count,
  output logic [31:0]             win_now
);
  localparam int unsigned SW = 12 + COUNT_WIDTH;

  logic [SW-1:0]          sum_r;
  logic [COUNT_WIDTH-1:0] count_r;
  logic [31:0]            start_r;
  logic [SW-1:0]          sum_add;
  logic [COUNT_WIDTH-1:0] count_add;
  logic [31:0]            elapsed;

  always_comb begin
    if (count_r != {COUNT_WIDTH{1'b1}}) begin
      sum_add   = sum_r + SW'(sample);
      count_add = count_r + COUNT_WIDTH'(1);
    end else begin
      sum_add   = sum_r;
      count_add = count_r;
    end
    elapsed   = now_ms - start_r;
    win_close = in_valid && (elapsed >= {16'd0, avg_period});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
      start_r <= '0;
    end else if (in_valid) begin
      if (win_close) begin
        sum_r   <= '0;
        count_r <= '0;
        start_r <= now_ms;
      end else begin
        sum_r   <= sum_add;
        count_r <= count_add;
      end
    end
  end

  assign win_sum   = sum_add;
  assign win_count = count_add;
  assign win_now   = now_ms;
endmodule

@@ src/pbrd_back.sv @@
// back end: mean, smoothing, beat detection, rate and classification
module pbrd_back #(
  parameter int unsigned SMOOTH_TAPS = 5,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      job_valid,
  input  logic [12+COUNT_WIDTH-1:0] job_sum,
  input  logic [COUNT_WIDTH-1:0]    job_count,
  input  logic [31:0]               job_now,
  output logic                      job_take,
  input  logic [11:0]               wave_low,
  input  logic [11:0]               wave_high,
  input  logic [15:0]               period_low,
  input  logic [15:0]               period_high,
  input  logic [15:0]               rate_low,
  input  logic [15:0]               rate_high,
  input  logic [15:0]               stability,
  output logic                      res_valid,
  input  logic                      res_take,
  output logic [15:0]               res_wave,
  output logic [2:0]                res_status,
  output logic [15:0]               res_rate,
  output logic [31:0]               res_period
);
  localparam int unsigned W   = pbrd_pkg::DIV_W;
  localparam int unsigned TPW = (SMOOTH_TAPS > 1) ? $clog2(SMOOTH_TAPS) : 1;
  // smoothing divide by a constant: reciprocal multiply, exact for 21-bit sums
  localparam int unsigned SM_SHIFT = 25;
  localparam logic [25:0] SM_MUL =
    26'((2**SM_SHIFT + SMOOTH_TAPS - 1) / SMOOTH_TAPS);

  pbrd_pkg::back_state_t state_r, state_nxt;
  pbrd_pkg::div_req_t    dreq;
  logic                  dstart, ddone;
  logic [W-1:0]          dquot;

  logic [15:0]     taps_r [SMOOTH_TAPS];
  logic [TPW-1:0]  tap_pos_r;
  logic [19:0]     tap_sum_r;
  logic [16:0]     wave_prev_r;
  logic            rising_r;
  logic [7:0]      rise_cnt_r;
  logic [31:0]     last_beat_r;
  logic [31:0]     per_hist_r [2];
  logic [15:0]     rate_hist_r [2];
  logic [15:0]     wave_r;
  logic [31:0]     period_r;
  logic [15:0]     rate_r;
  logic [2:0]      status_r;
  logic [31:0]     now_r;
  logic [20:0]     sm_num;
  logic [46:0]     sm_prod;
  logic [15:0]     wave_new;
  logic            wave_up, beat_now;
  logic [31:0]     per_now, per_sel;
  logic [35:0]     dsum;
  logic [15:0]     d0, d1;
  logic [16:0]     wlo, whi;

  pbrd_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dstart),
    .req   (dreq),
    .done  (ddone),
    .quot  (dquot)
  );

  assign sm_num   = 21'(tap_sum_r) + 21'(SMOOTH_TAPS / 2);
  assign sm_prod  = 47'(sm_num) * 47'(SM_MUL);
  assign wave_new = sm_prod[SM_SHIFT +: 16];
  assign wave_up  = {1'b0, wave_new} > wave_prev_r;
  assign beat_now = (state_r == pbrd_pkg::BK_SMOOTH) && wave_up && !rising_r
                    && (rise_cnt_r >= pbrd_pkg::RISE_LIMIT);

  // period of a new beat while smoothing, the stored period afterwards
  assign per_now = now_r - last_beat_r;
  assign per_sel = (state_r == pbrd_pkg::BK_SMOOTH) ? per_now : period_r;
  assign dsum = 36'({per_sel, 2'b00}) + 36'(per_hist_r[0]) * 36'd3
              + 36'(per_hist_r[1]) * 36'd3;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pbrd_pkg::BK_IDLE:   if (job_valid) state_nxt = pbrd_pkg::BK_MEAN;
      pbrd_pkg::BK_MEAN:   if (ddone) state_nxt = pbrd_pkg::BK_SMOOTH;
      pbrd_pkg::BK_SMOOTH: state_nxt = beat_now ? pbrd_pkg::BK_RATE
                                                : pbrd_pkg::BK_OUT;
      pbrd_pkg::BK_RATE:   if (ddone || dsum == '0) state_nxt = pbrd_pkg::BK_CLASS;
      pbrd_pkg::BK_CLASS:  state_nxt = pbrd_pkg::BK_OUT;
      pbrd_pkg::BK_OUT:    if (res_take) state_nxt = pbrd_pkg::BK_IDLE;
      default:             state_nxt = pbrd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    dstart = 1'b0;
    dreq   = '0;
    case (state_r)
      pbrd_pkg::BK_IDLE: begin
        dstart   = job_valid;
        dreq.num = W'({job_sum, 4'b0000}) + W'(job_count >> 1);
        dreq.den = W'(job_count);
      end
      pbrd_pkg::BK_SMOOTH: begin
        dstart   = beat_now;
        dreq.num = W'(pbrd_pkg::RATE_NUM) + W'(dsum >> 1);
        dreq.den = W'(dsum);
      end
      default: ;
    endcase
  end

  assign job_take = (state_r == pbrd_pkg::BK_IDLE) && job_valid;
  assign d0  = (rate_r > rate_hist_r[0]) ? rate_r - rate_hist_r[0]
                                         : rate_hist_r[0] - rate_r;
  assign d1  = (rate_r > rate_hist_r[1]) ? rate_r - rate_hist_r[1]
                                         : rate_hist_r[1] - rate_r;
  assign wlo = {1'b0, wave_low, 4'b0000};
  assign whi = {1'b0, wave_high, 4'b0000};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pbrd_pkg::BK_IDLE;
      for (int i = 0; i < SMOOTH_TAPS; i++) taps_r[i] <= '0;
      tap_pos_r   <= '0;
      tap_sum_r   <= '0;
      wave_prev_r <= pbrd_pkg::WAVE_RESET;
      rising_r    <= 1'b1;
      rise_cnt_r  <= '0;
      last_beat_r <= '0;
      per_hist_r[0]  <= '0;
      per_hist_r[1]  <= '0;
      rate_hist_r[0] <= pbrd_pkg::RATE_RESET;
      rate_hist_r[1] <= pbrd_pkg::RATE_RESET;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        pbrd_pkg::BK_IDLE: if (job_valid) now_r <= job_now;
        pbrd_pkg::BK_MEAN: if (ddone) begin
          tap_sum_r <= tap_sum_r - 20'(taps_r[tap_pos_r]) + 20'(dquot[15:0]);
          taps_r[tap_pos_r] <= dquot[15:0];
          tap_pos_r <= (tap_pos_r == TPW'(SMOOTH_TAPS - 1)) ? '0
                                                            : tap_pos_r + TPW'(1);
        end
        pbrd_pkg::BK_SMOOTH: begin
          wave_r      <= wave_new;
          status_r    <= pbrd_pkg::ST_NO_BEAT;
          rate_r      <= '0;
          period_r    <= beat_now ? per_now : '0;
          wave_prev_r <= {1'b0, wave_new};
          if (wave_up) begin
            if (rise_cnt_r != 8'hFF) rise_cnt_r <= rise_cnt_r + 8'd1;
            if (beat_now) begin
              last_beat_r <= now_r;
              rising_r    <= 1'b1;
            end
          end else begin
            rising_r   <= 1'b0;
            rise_cnt_r <= '0;
          end
        end
        pbrd_pkg::BK_RATE: begin
          if (dsum == '0) rate_r <= pbrd_pkg::RATE_SAT;
          else if (ddone)
            rate_r <= (dquot > W'(pbrd_pkg::RATE_SAT)) ? pbrd_pkg::RATE_SAT
                                                       : dquot[15:0];
        end
        pbrd_pkg::BK_CLASS: begin
          if ({1'b0, wave_r} < wlo || {1'b0, wave_r} > whi)
            status_r <= pbrd_pkg::ST_LEVEL_OUT;
          else if (period_r < {16'd0, period_low} || period_r > {16'd0, period_high})
            status_r <= pbrd_pkg::ST_PERIOD_OUT;
          else if (rate_r < rate_low || rate_r > rate_high)
            status_r <= pbrd_pkg::ST_RATE_OUT;
          else if (d0 > stability || d1 > stability)
            status_r <= pbrd_pkg::ST_UNSTABLE;
          else
            status_r <= pbrd_pkg::ST_VALID;
          rate_hist_r[1] <= rate_hist_r[0];
          rate_hist_r[0] <= rate_r;
          per_hist_r[1]  <= per_hist_r[0];
          per_hist_r[0]  <= period_r;
        end
        default: ;
      endcase
    end
  end

  assign res_valid  = (state_r == pbrd_pkg::BK_OUT);
  assign res_wave   = wave_r;
  assign res_status = status_r;
  assign res_rate   = rate_r;
  assign res_period = period_r;

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |=> state_r == pbrd_pkg::BK_MEAN)
    else $error("job taken outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_take |=> res_valid && $stable(res_wave))
    else $error("result dropped");
  a_nobeat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_status == pbrd_pkg::ST_NO_BEAT |-> res_rate == '0)
    else $error("rate without beat");
endmodule

@@ src/pulse_beat_rate_detector_top.sv @@
// top level of the pulse beat rate detector
// front accumulates one sample per cycle while not full; a window close queues a job
// mean uses the shared bit-serial divider (40 iterations plus load and done);
// a beat adds a rate divide, not waited for when the rate divisor is zero;
// smoothing is a combinational reciprocal multiply; full only while a closed
// window waits
// rst_n synchronous active low: registers to defaults, queues empty
module pulse_beat_rate_detector_top #(
  parameter int unsigned SMOOTH_TAPS = 5,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [11:0] in_sample,
  input  logic [31:0] in_now_ms,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_wave_q4,
  output logic [2:0]  out_beat_status,
  output logic [15:0] out_rate_x10,
  output logic [31:0] out_beat_period_ms,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [pbrd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int unsigned SW = 12 + COUNT_WIDTH;

  // configuration registers
  logic [15:0] avg_period_r, period_low_r, period_high_r;
  logic [15:0] rate_low_r, rate_high_r, stability_r;
  logic [11:0] wave_low_r, wave_high_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_period_r  <= 16'd20;
      wave_low_r    <= 12'd2400;
      wave_high_r   <= 12'd2900;
      period_low_r  <= 16'd500;
      period_high_r <= 16'd2000;
      rate_low_r    <= 16'd300;
      rate_high_r   <= 16'd1200;
      stability_r   <= 16'd100;
    end else if (cfg_valid) begin
      case (pbrd_pkg::cfg_reg_t'(cfg_index))
        pbrd_pkg::REG_AVG_PERIOD:  avg_period_r  <= cfg_data;
        pbrd_pkg::REG_WAVE_LOW:    wave_low_r    <= cfg_data[11:0];
        pbrd_pkg::REG_WAVE_HIGH:   wave_high_r   <= cfg_data[11:0];
        pbrd_pkg::REG_PERIOD_LOW:  period_low_r  <= cfg_data;
        pbrd_pkg::REG_PERIOD_HIGH: period_high_r <= cfg_data;
        pbrd_pkg::REG_RATE_LOW:    rate_low_r    <= cfg_data;
        pbrd_pkg::REG_RATE_HIGH:   rate_high_r   <= cfg_data;
        pbrd_pkg::REG_STABILITY:   stability_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // front end
  logic              accept, close;
  logic [SW-1:0]     w_sum;
  logic [COUNT_WIDTH-1:0] w_cnt;
  logic [31:0]       w_now;

  assign accept = push && !full;

  pbrd_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (accept),
    .sample     (in_sample),
    .now_ms     (in_now_ms),
    .avg_period (avg_period_r),
    .win_close  (close),
    .win_sum    (w_sum),
    .win_count  (w_cnt),
    .win_now    (w_now)
  );

  // one-entry job queue between front and back
  logic                   jq_valid_r;
  logic [SW-1:0]          jq_sum_r;
  logic [COUNT_WIDTH-1:0] jq_cnt_r;
  logic [31:0]            jq_now_r;
  logic                   job_take;

  // full while a closed window waits for the back end
  assign full = jq_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) jq_valid_r <= 1'b0;
    else if (accept && close) jq_valid_r <= 1'b1;
    else if (job_take) jq_valid_r <= 1'b0;
    if (accept && close) begin
      jq_sum_r <= w_sum;
      jq_cnt_r <= w_cnt;
      jq_now_r <= w_now;
    end
  end

  // back end
  logic        res_valid, res_take;
  logic [15:0] r_wave, r_rate;
  logic [2:0]  r_status;
  logic [31:0] r_period;

  pbrd_back #(.SMOOTH_TAPS(SMOOTH_TAPS), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_valid   (jq_valid_r),
    .job_sum     (jq_sum_r),
    .job_count   (jq_cnt_r),
    .job_now     (jq_now_r),
    .job_take    (job_take),
    .wave_low    (wave_low_r),
    .wave_high   (wave_high_r),
    .period_low  (period_low_r),
    .period_high (period_high_r),
    .rate_low    (rate_low_r),
    .rate_high   (rate_high_r),
    .stability   (stability_r),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res_wave    (r_wave),
    .res_status  (r_status),
    .res_rate    (r_rate),
    .res_period  (r_period)
  );

  // output register decouples the result from the pop side
  logic out_valid_r;
  assign res_take = res_valid && (!out_valid_r || pop);
  assign empty    = !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (res_take) out_valid_r <= 1'b1;
    else if (pop) out_valid_r <= 1'b0;
    if (res_take) begin
      out_wave_q4        <= r_wave;
      out_beat_status    <= r_status;
      out_rate_x10       <= r_rate;
      out_beat_period_ms <= r_period;
    end
  end

  a_full_no_close: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !(accept && close))
    else $error("window closed into full queue");
  a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !empty && !res_take |=> empty)
    else $error("request not removed");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_beat_status <= pbrd_pkg::ST_VALID)
    else $error("bad status code");
endmodule
